// File: hdl/mrr_pkg.sv
`default_nettype none
package mrr_pkg;

  localparam int WIDTH = 32;
  localparam int CntW  = $clog2(WIDTH);
  localparam int StepW = 4;

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [StepW-1:0] step_t;

  typedef enum logic [1:0] {
    V_PRIME     = 2'd0,
    V_COMPOSITE = 2'd1,
    V_INVALID   = 2'd2
  } verdict_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_STRIP,
    OP_SHR,
    OP_MUL_ACC_SQ,
    OP_MUL_SQ_SQ,
    OP_MUL_ACC_ACC,
    OP_DEC_S,
    OP_EMIT_COMP,
    OP_EMIT_PRIME,
    OP_EMIT_INV
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_INVALID,
    C_R_EVEN,
    C_R_ZERO,
    C_ACC_END,
    C_S_LE1,
    C_ACC_NM1,
    C_ACC_NOT_ONE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ucode_t;

  typedef struct packed {
    logic invalid;
    logic r_even;
    logic r_zero;
    logic acc_end;
    logic s_le1;
    logic acc_nm1;
    logic acc_not_one;
    logic in_valid;
    logic mul_done;
    logic out_free;
  } flags_t;

  // program labels
  localparam step_t L_LOAD      = step_t'(0);
  localparam step_t L_STRIP     = step_t'(1);
  localparam step_t L_PLOOP     = step_t'(2);
  localparam step_t L_PBIT      = step_t'(3);
  localparam step_t L_PMUL      = step_t'(4);
  localparam step_t L_PSQ       = step_t'(5);
  localparam step_t L_PSHR      = step_t'(6);
  localparam step_t L_POST      = step_t'(7);
  localparam step_t L_SLOOP     = step_t'(8);
  localparam step_t L_SSQ       = step_t'(9);
  localparam step_t L_SDEC      = step_t'(10);
  localparam step_t L_SONE      = step_t'(11);
  localparam step_t L_COMPOSITE = step_t'(12);
  localparam step_t L_PRIME     = step_t'(13);
  localparam step_t L_INVALID   = step_t'(14);

  function automatic ucode_t ucode(input step_t pc);
    ucode_t u;
    u = '{op: OP_NOP, cond: C_ALWAYS, target: L_LOAD};
    case (pc)
      L_LOAD:      u = '{op: OP_LOAD,        cond: C_INVALID,     target: L_INVALID};
      L_STRIP:     u = '{op: OP_STRIP,       cond: C_R_EVEN,      target: L_STRIP};
      L_PLOOP:     u = '{op: OP_NOP,         cond: C_R_ZERO,      target: L_POST};
      L_PBIT:      u = '{op: OP_NOP,         cond: C_R_EVEN,      target: L_PSQ};
      L_PMUL:      u = '{op: OP_MUL_ACC_SQ,  cond: C_NEVER,       target: L_LOAD};
      L_PSQ:       u = '{op: OP_MUL_SQ_SQ,   cond: C_NEVER,       target: L_LOAD};
      L_PSHR:      u = '{op: OP_SHR,         cond: C_ALWAYS,      target: L_PLOOP};
      L_POST:      u = '{op: OP_NOP,         cond: C_ACC_END,     target: L_PRIME};
      L_SLOOP:     u = '{op: OP_NOP,         cond: C_S_LE1,       target: L_COMPOSITE};
      L_SSQ:       u = '{op: OP_MUL_ACC_ACC, cond: C_NEVER,       target: L_LOAD};
      L_SDEC:      u = '{op: OP_DEC_S,       cond: C_ACC_NM1,     target: L_PRIME};
      L_SONE:      u = '{op: OP_NOP,         cond: C_ACC_NOT_ONE, target: L_SLOOP};
      L_COMPOSITE: u = '{op: OP_EMIT_COMP,   cond: C_ALWAYS,      target: L_LOAD};
      L_PRIME:     u = '{op: OP_EMIT_PRIME,  cond: C_ALWAYS,      target: L_LOAD};
      L_INVALID:   u = '{op: OP_EMIT_INV,    cond: C_ALWAYS,      target: L_LOAD};
      default:     u = '{op: OP_NOP,         cond: C_ALWAYS,      target: L_LOAD};
    endcase
    return u;
  endfunction

  // (x + y) mod m for x, y < m
  function automatic word_t add_mod(input word_t x, input word_t y, input word_t m);
    word_t room;
    room = m - y;
    if (x >= room) begin
      return x - room;
    end else begin
      return x + y;
    end
  endfunction

endpackage
`default_nettype wire

// File: hdl/mrr_req_if.sv
`default_nettype none
interface mrr_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] candidate;
  logic [31:0] witness;

  modport source (output valid, output candidate, output witness, input ready);
  modport sink   (input valid, input candidate, input witness, output ready);
endinterface
`default_nettype wire

// File: hdl/mrr_rsp_if.sv
`default_nettype none
interface mrr_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;

  modport source (output valid, output verdict, input ready);
  modport sink   (input valid, input verdict, output ready);
endinterface
`default_nettype wire

// File: hdl/mrr_mulmod.sv
`default_nettype none
module mrr_mulmod
  import mrr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire word_t x,
  input  wire word_t y,
  input  wire word_t m,
  output logic       done,
  output word_t      prod
);

  logic  busy;
  cnt_t  cnt;
  word_t p;
  word_t xr;
  word_t yr;
  word_t mr;
  word_t dbl;
  word_t p_next;

  // one multiplier bit per cycle, most significant first
  always_comb begin
    dbl    = add_mod(p, p, mr);
    p_next = yr[WIDTH-1] ? add_mod(dbl, xr, mr) : dbl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      p   <= '0;
      xr  <= x;
      yr  <= y;
      mr  <= m;
      cnt <= cnt_t'(WIDTH - 1);
    end else if (busy) begin
      p   <= p_next;
      yr  <= {yr[WIDTH-2:0], 1'b0};
      cnt <= cnt - 1'b1;
    end
  end

  assign prod = p;

endmodule
`default_nettype wire

// File: hdl/mrr_seq.sv
`default_nettype none
module mrr_seq
  import mrr_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire flags_t flags,
  output op_t         op,
  output logic        fire,
  output logic        mul_start
);

  step_t  pc;
  step_t  pc_next;
  ucode_t uc;
  logic   launched;
  logic   is_mul;
  logic   take;

  always_comb begin
    uc     = ucode(pc);
    op     = uc.op;
    is_mul = (uc.op == OP_MUL_ACC_SQ) || (uc.op == OP_MUL_SQ_SQ) ||
             (uc.op == OP_MUL_ACC_ACC);

    case (uc.op)
      OP_LOAD:                                    fire = flags.in_valid;
      OP_MUL_ACC_SQ, OP_MUL_SQ_SQ, OP_MUL_ACC_ACC: fire = flags.mul_done;
      OP_EMIT_COMP, OP_EMIT_PRIME, OP_EMIT_INV:   fire = flags.out_free;
      default:                                    fire = 1'b1;
    endcase

    case (uc.cond)
      C_NEVER:       take = 1'b0;
      C_ALWAYS:      take = 1'b1;
      C_INVALID:     take = flags.invalid;
      C_R_EVEN:      take = flags.r_even;
      C_R_ZERO:      take = flags.r_zero;
      C_ACC_END:     take = flags.acc_end;
      C_S_LE1:       take = flags.s_le1;
      C_ACC_NM1:     take = flags.acc_nm1;
      C_ACC_NOT_ONE: take = flags.acc_not_one;
      default:       take = 1'b0;
    endcase

    mul_start = is_mul && !launched;

    if (fire) begin
      pc_next = take ? uc.target : step_t'(pc + 1'b1);
    end else begin
      pc_next = pc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= L_LOAD;
      launched <= 1'b0;
    end else begin
      pc <= pc_next;
      if (fire) begin
        launched <= 1'b0;
      end else if (mul_start) begin
        launched <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/miller_rabin_round.sv
`default_nettype none
// One Miller-Rabin round on an odd candidate n with witness a, one beat at a time:
// the block takes a request, returns one verdict (0 probable prime, 1 composite,
// 2 invalid input) and only then takes the next request. Invalid input (n below 3,
// n even, a outside 2..n-2) skips the program: the load step branches to the invalid emit.
// Otherwise a small microcode program strips n-1 to r*2^s, forms a^r mod n by
// square-and-multiply, then squares up to s-1 more times.
// All products go through one shared modular multiplier that retires one bit per
// cycle, and an item needs at most about 2*WIDTH products.
// The verdict sits in an output register, so a stalled response does not block the
// multiplier work already finished.
module miller_rabin_round
  import mrr_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  mrr_req_if.sink  req,
  mrr_rsp_if.source rsp
);

  op_t    op;
  logic   fire;
  logic   mul_start;
  logic   mul_done;
  flags_t flags;

  word_t  n;
  word_t  nm1;
  word_t  r;
  cnt_t   s;
  word_t  acc;
  word_t  sq;
  word_t  prod;
  word_t  mx;
  word_t  my;
  word_t  cand;
  word_t  wit;
  logic   out_valid;
  verdict_t verdict;

  assign cand = word_t'(req.candidate);
  assign wit  = word_t'(req.witness);

  always_comb begin
    flags.invalid     = (cand < word_t'(3)) || !cand[0] || (wit < word_t'(2)) ||
                        (wit > cand - word_t'(2));
    flags.r_even      = !r[0];
    flags.r_zero      = (r == '0);
    flags.acc_end     = (acc == word_t'(1)) || (acc == nm1);
    flags.s_le1       = (s <= cnt_t'(1));
    flags.acc_nm1     = (acc == nm1);
    flags.acc_not_one = (acc != word_t'(1));
    flags.in_valid    = req.valid;
    flags.mul_done    = mul_done;
    flags.out_free    = !out_valid || rsp.ready;
  end

  mrr_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .flags     (flags),
    .op        (op),
    .fire      (fire),
    .mul_start (mul_start)
  );

  // operand select for the shared multiplier
  always_comb begin
    mx = (op == OP_MUL_SQ_SQ) ? sq : acc;
    my = (op == OP_MUL_ACC_ACC) ? acc : sq;
  end

  mrr_mulmod u_mulmod (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .x     (mx),
    .y     (my),
    .m     (n),
    .done  (mul_done),
    .prod  (prod)
  );

  always_ff @(posedge clk) begin
    if (fire) begin
      case (op)
        OP_LOAD: begin
          n   <= cand;
          nm1 <= cand - word_t'(1);
          r   <= cand - word_t'(1);
          s   <= '0;
          acc <= word_t'(1);
          sq  <= wit;
        end
        OP_STRIP: begin
          if (!r[0]) begin
            r <= r >> 1;
            s <= s + 1'b1;
          end
        end
        OP_SHR:         r   <= r >> 1;
        OP_MUL_ACC_SQ:  acc <= prod;
        OP_MUL_ACC_ACC: acc <= prod;
        OP_MUL_SQ_SQ:   sq  <= prod;
        OP_DEC_S:       s   <= s - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && (op == OP_EMIT_COMP || op == OP_EMIT_PRIME ||
                          op == OP_EMIT_INV)) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      case (op)
        OP_EMIT_COMP:  verdict <= V_COMPOSITE;
        OP_EMIT_PRIME: verdict <= V_PRIME;
        OP_EMIT_INV:   verdict <= V_INVALID;
        default: ;
      endcase
    end
  end

  assign req.ready   = (op == OP_LOAD);
  assign rsp.valid   = out_valid;
  assign rsp.verdict = verdict;

endmodule
`default_nettype wire
